>>> hw/rtl/hll_pkg.sv
// hll_pkg: shared types, constants and helper functions for the hyperloglog sketch
// no dependencies
package hll_pkg;

    localparam int MAX_PRECISION = 14;
    localparam int IDX_W         = MAX_PRECISION;
    localparam int DEPTH         = 1 << MAX_PRECISION;
    localparam int SUM_W         = MAX_PRECISION + 34;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

    localparam logic [3:0] P_MIN   = 4'd4;
    localparam logic [3:0] P_MAX   = 4'(MAX_PRECISION);
    localparam logic [3:0] P_RESET = 4'd14;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_MERGE    = 2'd1;
    localparam logic [1:0] OP_ESTIMATE = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    localparam logic [1:0] CORR_RAW    = 2'd0;
    localparam logic [1:0] CORR_LINEAR = 2'd1;
    localparam logic [1:0] CORR_LARGE  = 2'd2;

    localparam logic [5:0]  RANK_MAX = 6'd33;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;

    localparam longint unsigned A4 = ((64'd673 << 32) + 64'd500) / 64'd1000;
    localparam longint unsigned A5 = ((64'd697 << 32) + 64'd500) / 64'd1000;
    localparam longint unsigned A6 = ((64'd709 << 32) + 64'd500) / 64'd1000;
    localparam longint unsigned D7  = 64'd10 * (64'd1000 * 64'd128 + 64'd1079);
    localparam longint unsigned D8  = 64'd10 * (64'd1000 * 64'd256 + 64'd1079);
    localparam longint unsigned D9  = 64'd10 * (64'd1000 * 64'd512 + 64'd1079);
    localparam longint unsigned D10 = 64'd10 * (64'd1000 * 64'd1024 + 64'd1079);
    localparam longint unsigned D11 = 64'd10 * (64'd1000 * 64'd2048 + 64'd1079);
    localparam longint unsigned D12 = 64'd10 * (64'd1000 * 64'd4096 + 64'd1079);
    localparam longint unsigned D13 = 64'd10 * (64'd1000 * 64'd8192 + 64'd1079);
    localparam longint unsigned D14 = 64'd10 * (64'd1000 * 64'd16384 + 64'd1079);
    localparam longint unsigned A7  = (((64'd7213 * 64'd128) << 32) + D7 / 2) / D7;
    localparam longint unsigned A8  = (((64'd7213 * 64'd256) << 32) + D8 / 2) / D8;
    localparam longint unsigned A9  = (((64'd7213 * 64'd512) << 32) + D9 / 2) / D9;
    localparam longint unsigned A10 = (((64'd7213 * 64'd1024) << 32) + D10 / 2) / D10;
    localparam longint unsigned A11 = (((64'd7213 * 64'd2048) << 32) + D11 / 2) / D11;
    localparam longint unsigned A12 = (((64'd7213 * 64'd4096) << 32) + D12 / 2) / D12;
    localparam longint unsigned A13 = (((64'd7213 * 64'd8192) << 32) + D13 / 2) / D13;
    localparam longint unsigned A14 = (((64'd7213 * 64'd16384) << 32) + D14 / 2) / D14;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] hash_value;
        logic [13:0] reg_index;
        logic [5:0]  reg_value;
    } in_t;

    typedef struct packed {
        logic [47:0] estimate_q16;
        logic        saturated;
        logic [1:0]  correction_used;
    } out_t;

    typedef struct packed {
        logic             est;
        logic [IDX_W-1:0] idx;
        logic [5:0]       val;
    } cmd_t;

    function automatic logic [3:0] eff_p(logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (r < P_MIN) r = P_MIN;
        if (r > P_MAX) r = P_MAX;
        return r;
    endfunction

    function automatic logic [31:0] alpha_q32(logic [3:0] p);
        logic [31:0] a;
        case (p)
            4'd4:    a = A4[31:0];
            4'd5:    a = A5[31:0];
            4'd6:    a = A6[31:0];
            4'd7:    a = A7[31:0];
            4'd8:    a = A8[31:0];
            4'd9:    a = A9[31:0];
            4'd10:   a = A10[31:0];
            4'd11:   a = A11[31:0];
            4'd12:   a = A12[31:0];
            4'd13:   a = A13[31:0];
            default: a = A14[31:0];
        endcase
        return a;
    endfunction

endpackage

>>> hw/rtl/hll_ram.sv
// hll_ram: generic single write, single read ram with registered read data
// no dependencies
module hll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/hll_fe.sv
// hll_fe: front end, accepts beats and turns them into register update or estimate commands
// depends on hll_pkg
module hll_fe (
    input  logic          s_valid,
    output logic          s_ready,
    input  hll_pkg::in_t  s_data,
    input  logic [3:0]    p,
    input  logic          clr_done,
    input  logic          push_ready,
    output logic          push_valid,
    output hll_pkg::cmd_t push_cmd
);
    import hll_pkg::*;

    logic [31:0]    hidx;
    logic [31:0]    hb;
    logic [5:0]     rank;
    logic [IDX_W:0] m;
    logic           keep;
    logic [5:0]     mval;

    always_comb begin
        hidx = s_data.hash_value >> (6'd32 - {2'b0, p});
        hb   = s_data.hash_value << p;
        rank = RANK_MAX;
        for (int i = 0; i < 32; i++) begin
            if (hb[i]) rank = 6'(32 - i);
        end
        m    = (IDX_W+1)'(1) << p;
        mval = (s_data.reg_value > RANK_MAX) ? RANK_MAX : s_data.reg_value;

        push_cmd = '0;
        keep     = 1'b0;
        case (s_data.opcode)
            OP_INSERT: begin
                keep         = 1'b1;
                push_cmd.idx = hidx[IDX_W-1:0] & IDX_W'(m - 1'b1);
                push_cmd.val = rank;
            end
            OP_MERGE: begin
                keep         = ({1'b0, s_data.reg_index} < m);
                push_cmd.idx = s_data.reg_index;
                push_cmd.val = mval;
            end
            OP_ESTIMATE: begin
                keep         = 1'b1;
                push_cmd.est = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign s_ready    = push_ready & clr_done;
    assign push_valid = s_valid & s_ready & keep;
endmodule

>>> hw/rtl/hll_fifo.sv
// hll_fifo: short command queue between front end and back end
// depends on hll_pkg
module hll_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  hll_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output hll_pkg::cmd_t pop_cmd
);
    import hll_pkg::*;

    cmd_t               q_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign push_ready = (cnt_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = q_reg[rp_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb begin
        wp_next  = do_push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_reg[wp_reg] <= push_cmd;
        end
    end
endmodule

>>> hw/rtl/hll_be.sv
// hll_be: back end, rank store read-modify-write, estimate sweep, divider, log and corrections
// depends on hll_pkg and hll_ram
module hll_be (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [3:0]    p,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  hll_pkg::cmd_t pop_cmd,
    output logic          clr_done,
    output logic          m_valid,
    input  logic          m_ready,
    output hll_pkg::out_t m_data
);
    import hll_pkg::*;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_RD   = 4'd2;
    localparam logic [3:0] ST_SUM  = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_DEC  = 4'd5;
    localparam logic [3:0] ST_NORM = 4'd6;
    localparam logic [3:0] ST_LOG  = 4'd7;
    localparam logic [3:0] ST_MUL  = 4'd8;
    localparam logic [3:0] ST_ADD  = 4'd9;
    localparam logic [3:0] ST_FIN  = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W:0]   cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic             out_vld_reg, out_vld_next;
    cmd_t             cmd_reg, cmd_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [IDX_W:0]   zeros_reg, zeros_next;
    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [49:0]      q_reg, q_next;
    logic             over_reg, over_next;
    logic [31:0]      a_reg, a_next;
    logic [48:0]      x_reg, x_next;
    logic [5:0]       n_reg, n_next;
    logic [30:0]      y_reg, y_next;
    logic [31:0]      frac_reg, frac_next;
    logic             lin_reg, lin_next;
    logic [37:0]      ph_reg, ph_next;
    logic [63:0]      pl_reg, pl_next;
    out_t             res_reg, res_next;
    out_t             out_reg, out_next;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [5:0]       wdata, rdata;

    logic [IDX_W:0]   m;
    logic [6:0]       total;
    logic [5:0]       r;
    logic [SUM_W:0]   rem_s;
    logic             qbit;
    logic [49:0]      q_new, raw;
    logic [49:0]      lin_thr;
    logic [54:0]      raw30;
    logic [61:0]      prod;
    logic [31:0]      sq;
    logic [37:0]      lg, l;
    logic [38:0]      ln;
    logic [63:0]      lsh;

    hll_ram #(.WIDTH(6), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign clr_done  = (state_reg != ST_CLR);
    assign pop_ready = (state_reg == ST_IDLE);
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;
    assign raddr     = (state_reg == ST_SUM) ? cnt_reg[IDX_W-1:0] : pop_cmd.idx;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        out_vld_next = out_vld_reg;
        cmd_next     = cmd_reg;
        sum_next     = sum_reg;
        zeros_next   = zeros_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        over_next    = over_reg;
        a_next       = a_reg;
        x_next       = x_reg;
        n_next       = n_reg;
        y_next       = y_reg;
        frac_next    = frac_reg;
        lin_next     = lin_reg;
        ph_next      = ph_reg;
        pl_next      = pl_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        we           = 1'b0;
        waddr        = cmd_reg.idx;
        wdata        = cmd_reg.val;

        m       = (IDX_W+1)'(1) << p;
        total   = 7'd49 + {2'b0, p, 1'b0};
        r       = (rdata > RANK_MAX) ? RANK_MAX : rdata;
        rem_s   = {rem_reg, a_reg[31]};
        qbit    = 1'b0;
        q_new   = '0;
        raw     = over_reg ? (50'd1 << 49) : q_reg;
        lin_thr = 50'd5 << (6'd15 + {2'b0, p});
        raw30   = {raw, 5'b0} - {4'b0, raw, 1'b0};
        prod    = 62'(y_reg) * 62'(y_reg);
        sq      = prod[61:30];
        lg      = {n_reg, frac_reg};
        l       = (lin_reg ? {2'b0, p, 32'b0} : {6'd48, 32'b0}) - lg;
        ln      = 39'(ph_reg) + 39'(pl_reg[63:32]);
        lsh     = 64'(ln) << p;

        if (m_ready) out_vld_next = 1'b0;

        case (state_reg)
            ST_CLR: begin
                we       = 1'b1;
                waddr    = cnt_reg[IDX_W-1:0];
                wdata    = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (IDX_W+1)'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
            end
            ST_IDLE: begin
                if (pop_valid) begin
                    cmd_next = pop_cmd;
                    if (pop_cmd.est) begin
                        state_next = ST_SUM;
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        sum_next   = '0;
                        zeros_next = '0;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                we         = (rdata < cmd_reg.val);
                state_next = ST_IDLE;
            end
            ST_SUM: begin
                if (cnt_reg < m) begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    sum_next   = sum_reg + (SUM_W'(1) << (RANK_MAX - r));
                    zeros_next = zeros_reg + (IDX_W+1)'(r == '0);
                end
                if (cnt_reg == m && !pend_reg) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                    rem_next   = '0;
                    q_next     = '0;
                    over_next  = 1'b0;
                    a_next     = alpha_q32(p);
                end
            end
            ST_DIV: begin
                a_next = a_reg << 1;
                if (rem_s >= {1'b0, sum_reg}) begin
                    rem_next = SUM_W'(rem_s - {1'b0, sum_reg});
                    qbit     = 1'b1;
                end else begin
                    rem_next = rem_s[SUM_W-1:0];
                end
                q_new = {q_reg[48:0], qbit};
                if (!over_reg) begin
                    q_next = q_new;
                    if (q_new[49]) over_next = 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (IDX_W+1)'(total - 1'b1)) state_next = ST_DEC;
            end
            ST_DEC: begin
                res_next.estimate_q16    = raw[47:0];
                res_next.saturated       = 1'b0;
                res_next.correction_used = CORR_RAW;
                n_next                   = 6'd48;
                state_next               = ST_FIN;
                if (raw <= lin_thr) begin
                    if (zeros_reg != '0) begin
                        lin_next   = 1'b1;
                        x_next     = 49'(zeros_reg);
                        state_next = ST_NORM;
                    end
                end else if (raw30 > (55'd1 << 48)) begin
                    res_next.correction_used = CORR_LARGE;
                    if (raw >= (50'd1 << 48)) begin
                        res_next.estimate_q16 = '1;
                        res_next.saturated    = 1'b1;
                    end else begin
                        lin_next   = 1'b0;
                        x_next     = 49'((50'd1 << 48) - raw);
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM: begin
                if (x_reg[48]) begin
                    y_next     = x_reg[48:18];
                    cnt_next   = '0;
                    frac_next  = '0;
                    state_next = ST_LOG;
                end else begin
                    x_next = x_reg << 1;
                    n_next = n_reg - 1'b1;
                end
            end
            ST_LOG: begin
                if (sq[31]) begin
                    y_next    = sq[31:1];
                    frac_next = {frac_reg[30:0], 1'b1};
                end else begin
                    y_next    = sq[30:0];
                    frac_next = {frac_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (IDX_W+1)'(31)) state_next = ST_MUL;
            end
            ST_MUL: begin
                ph_next    = 38'(l[37:32]) * 38'(LN2_Q32);
                pl_next    = 64'(l[31:0]) * 64'(LN2_Q32);
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (lin_reg) begin
                    res_next.estimate_q16    = lsh[63:16];
                    res_next.saturated       = 1'b0;
                    res_next.correction_used = CORR_LINEAR;
                end else if (ln[38:32] != '0) begin
                    res_next.estimate_q16    = '1;
                    res_next.saturated       = 1'b1;
                    res_next.correction_used = CORR_LARGE;
                end else begin
                    res_next.estimate_q16    = {ln[31:0], 16'b0};
                    res_next.saturated       = 1'b0;
                    res_next.correction_used = CORR_LARGE;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!out_vld_reg || m_ready) begin
                    out_vld_next = 1'b1;
                    out_next     = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        sum_reg   <= sum_next;
        zeros_reg <= zeros_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        over_reg  <= over_next;
        a_reg     <= a_next;
        x_reg     <= x_next;
        n_reg     <= n_next;
        y_reg     <= y_next;
        frac_reg  <= frac_next;
        lin_reg   <= lin_next;
        ph_reg    <= ph_next;
        pl_reg    <= pl_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end
endmodule

>>> hw/rtl/hyperloglog_cardinality_sketch_top.sv
// hyperloglog_cardinality_sketch_top: hyperloglog sketch, front end, command queue, back end
// depends on hll_pkg, hll_fe, hll_fifo, hll_be
// insert and merge beats pass through the back end as a rank store read, then a write if the new rank is larger
// estimate: a pop, a sweep over the M registers, the divider steps, a decision step,
// normalize and log steps, then multiply, add and finish; raw results and those saturated
// at the decision skip normalize and log; the result sits in an output register until taken
// after reset the whole rank store is cleared, during which no beat is accepted
module hyperloglog_cardinality_sketch_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hll_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output hll_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [3:0]    cfg_wdata
);
    import hll_pkg::*;

    logic [3:0] prec_reg, prec_next;
    logic [3:0] p;
    logic       clr_done;
    logic       push_valid, push_ready, pop_valid, pop_ready;
    cmd_t       push_cmd, pop_cmd;

    assign cfg_ready = 1'b1;
    assign prec_next = (cfg_valid && cfg_ready) ? cfg_wdata : prec_reg;
    assign p         = eff_p(prec_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prec_reg <= P_RESET;
        end else begin
            prec_reg <= prec_next;
        end
    end

    hll_fe u_fe (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .p          (p),
        .clr_done   (clr_done),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    hll_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    hll_be u_be (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .p         (p),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .clr_done  (clr_done),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );
endmodule

>>> sim/hyperloglog_cardinality_sketch_top_tb.sv
// testbench for hyperloglog_cardinality_sketch_top: directed and random insert, merge and
// estimate beats checked against a built-in sketch predictor; depends on hll_pkg and the rtl
`timescale 1ns / 1ps

module hyperloglog_cardinality_sketch_top_tb;
    import hll_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_wdata = '0;

    logic [5:0] rank_shadow [DEPTH];
    logic [3:0] prec_shadow;
    out_t pending_estimates [$];
    int mismatches = 0;
    int idle_cycles = 0;
    int beats_sent = 0;
    int estimates_seen = 0;
    int corr_seen [4] = '{0, 0, 0, 0};
    int saturated_seen = 0;
    bit quiet = 1'b0;

    hyperloglog_cardinality_sketch_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic int unsigned live_prec();
        int unsigned p;
        p = 32'(prec_shadow);
        if (p < 4) p = 4;
        if (p > MAX_PRECISION) p = MAX_PRECISION;
        return p;
    endfunction

    function automatic longint unsigned log2_fixed(longint unsigned x);
        int unsigned n;
        longint unsigned y, r;
        n = 0;
        if (x == 0) return 0;
        while (n < 63 && (x >> (n + 1)) != 0) n++;
        y = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
        r = longint'(n) << 32;
        for (int i = 31; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
                y = y >> 1;
                r = r | (64'd1 << i);
            end
        end
        return r;
    endfunction

    function automatic longint unsigned scale_ln2(longint unsigned v);
        return (v >> 32) * 64'd2977044472 + (((v & 64'hFFFF_FFFF) * 64'd2977044472) >> 32);
    endfunction

    function automatic out_t predict_estimate();
        int unsigned p, s;
        longint unsigned m, sum, zeros, a, den, rem, q, raw, bitv, d, l, ln;
        bit over;
        out_t res;
        p = live_prec();
        m = 64'd1 << p;
        sum = 0;
        zeros = 0;
        for (int i = 0; i < m; i++) begin
            sum += 64'd1 << (33 - rank_shadow[i]);
            if (rank_shadow[i] == 0) zeros++;
        end
        if (p == 4) a = ((64'd673 << 32) + 500) / 1000;
        else if (p == 5) a = ((64'd697 << 32) + 500) / 1000;
        else if (p == 6) a = ((64'd709 << 32) + 500) / 1000;
        else begin
            den = 10 * (1000 * m + 1079);
            a = (((64'd7213 * m) << 32) + den / 2) / den;
        end
        s = 2 * p + 17;
        rem = 0;
        q = 0;
        over = 0;
        for (int unsigned i = 0; i < 32 + s; i++) begin
            bitv = (i < 32) ? ((a >> (31 - i)) & 1) : 0;
            rem = (rem << 1) | bitv;
            bitv = 0;
            if (rem >= sum) begin
                rem -= sum;
                bitv = 1;
            end
            if (!over) begin
                q = (q << 1) | bitv;
                if (q >= (64'd1 << 49)) over = 1;
            end
        end
        raw = over ? (64'd1 << 49) : q;
        res.estimate_q16 = 48'(raw);
        res.saturated = 1'b0;
        res.correction_used = CORR_RAW;
        if (raw <= ((5 * m) << 15)) begin
            if (zeros != 0) begin
                l = (longint'(p) << 32) - log2_fixed(zeros);
                ln = scale_ln2(l);
                res.estimate_q16 = 48'((ln << p) >> 16);
                res.correction_used = CORR_LINEAR;
            end
        end else if (raw * 30 > (64'd1 << 48)) begin
            res.correction_used = CORR_LARGE;
            if (raw >= (64'd1 << 48)) begin
                res.estimate_q16 = 48'(MASK48);
                res.saturated = 1'b1;
            end else begin
                d = (64'd1 << 48) - raw;
                l = (64'd48 << 32) - log2_fixed(d);
                ln = scale_ln2(l);
                if (ln >= (64'd1 << 32)) begin
                    res.estimate_q16 = 48'(MASK48);
                    res.saturated = 1'b1;
                end else begin
                    res.estimate_q16 = 48'(ln << 16);
                end
            end
        end
        return res;
    endfunction

    function automatic void apply_beat(in_t b);
        int unsigned p, w, idx;
        logic [31:0] shifted;
        logic [5:0] v;
        p = live_prec();
        case (b.opcode)
            OP_INSERT: begin
                idx = b.hash_value >> (32 - p);
                shifted = b.hash_value << p;
                w = 1;
                for (int i = 31; i >= 0 && !shifted[i]; i--) w++;
                if (rank_shadow[idx] < w) rank_shadow[idx] = 6'(w);
            end
            OP_MERGE: begin
                v = (b.reg_value > RANK_MAX) ? RANK_MAX : b.reg_value;
                if (b.reg_index < (1 << p) && rank_shadow[b.reg_index] < v)
                    rank_shadow[b.reg_index] = v;
            end
            OP_ESTIMATE: pending_estimates.push_back(predict_estimate());
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_estimates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_data);
            end else begin
                out_t exp_r;
                exp_r = pending_estimates.pop_front();
                estimates_seen++;
                corr_seen[exp_r.correction_used]++;
                if (exp_r.saturated) saturated_seen++;
                if (m_data !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("estimate mismatch: exp %h sat %b corr %0d, got %h sat %b corr %0d",
                                 exp_r.estimate_q16, exp_r.saturated, exp_r.correction_used,
                                 m_data.estimate_q16, m_data.saturated, m_data.correction_used);
                end
            end
        end
    end

    // result receiver with random stalls
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            gap = quiet ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
                @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d estimates outstanding", pending_estimates.size());
            $display("FAIL hyperloglog_cardinality_sketch_top");
            $finish;
        end
    end

    task automatic send_beat(in_t b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = b;
        do @(posedge aclk); while (!s_ready);
        apply_beat(b);
        beats_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        wait (pending_estimates.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_precision(logic [3:0] v);
        drain();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_wdata = v;
        do @(posedge aclk); while (!cfg_ready);
        prec_shadow = v;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic in_t make_beat(logic [1:0] op, logic [31:0] h,
                                      logic [13:0] idx, logic [5:0] v);
        in_t b;
        b.opcode = op;
        b.hash_value = h;
        b.reg_index = idx;
        b.reg_value = v;
        return b;
    endfunction

    function automatic in_t random_beat(logic [1:0] op);
        return make_beat(op, $urandom, 14'($urandom), 6'($urandom));
    endfunction

    task automatic fill_all(int lo, int hi);
        for (int i = 0; i < (1 << live_prec()); i++)
            send_beat(make_beat(OP_MERGE, $urandom, 14'(i), 6'($urandom_range(lo, hi))));
    endtask

    task automatic test_empty_full_precision();
        send_beat(make_beat(OP_ESTIMATE, '0, '0, '0));
        drain();
    endtask

    task automatic test_directed_edges();
        write_precision(4'd4);
        send_beat(make_beat(OP_INSERT, 32'h0000_0000, '0, '0));
        send_beat(make_beat(OP_INSERT, 32'hFFFF_FFFF, '0, '0));
        send_beat(make_beat(OP_INSERT, 32'h8000_0000, '0, '0));
        send_beat(make_beat(OP_INSERT, 32'h0800_0000, '0, '0));
        send_beat(make_beat(OP_ESTIMATE, '0, '0, '0));
        send_beat(make_beat(OP_MERGE, '0, 14'd16383, 6'd33));
        send_beat(make_beat(OP_MERGE, '0, 14'd16, 6'd20));
        send_beat(make_beat(OP_MERGE, '0, 14'd0, 6'd63));
        send_beat(make_beat(OP_MERGE, '0, 14'd5, 6'd0));
        send_beat(make_beat(OP_MERGE, '0, 14'd15, 6'd34));
        send_beat(make_beat(OP_NOP, 32'hFFFF_FFFF, 14'h3FFF, 6'h3F));
        send_beat(make_beat(OP_ESTIMATE, '0, '0, '0));
        drain();
        fill_all(3, 6);
        send_beat(make_beat(OP_ESTIMATE, '0, '0, '0));
        fill_all(24, 24);
        send_beat(make_beat(OP_ESTIMATE, '0, '0, '0));
        fill_all(33, 33);
        send_beat(make_beat(OP_ESTIMATE, '0, '0, '0));
        drain();
    endtask

    task automatic test_precision_clamps();
        write_precision(4'd0);
        send_beat(make_beat(OP_ESTIMATE, '0, '0, '0));
        write_precision(4'd15);
        send_beat(make_beat(OP_INSERT, 32'h1234_5678, '0, '0));
        send_beat(make_beat(OP_ESTIMATE, '0, '0, '0));
        write_precision(4'd5);
        send_beat(make_beat(OP_ESTIMATE, '0, '0, '0));
        drain();
    endtask

    task automatic test_random_phases();
        int unsigned p_choice, n, r, est_odds;
        for (int ph = 0; ph < 9; ph++) begin
            p_choice = (ph == 4) ? 12 : (ph == 7) ? 14 : $urandom_range(0, 10);
            write_precision(4'(p_choice));
            quiet = (ph % 3 == 2);
            est_odds = (live_prec() <= 10) ? 25 : 120;
            if (live_prec() <= 6 && $urandom_range(0, 1)) fill_all(14, 33);
            n = 0;
            while (n < 130) begin
                r = $urandom_range(0, 99);
                if ($urandom_range(0, est_odds - 1) == 0)
                    send_beat(random_beat(OP_ESTIMATE));
                else if (r < 70)
                    send_beat(random_beat(OP_INSERT));
                else if (r < 95)
                    send_beat(random_beat(OP_MERGE));
                else
                    send_beat(random_beat(OP_NOP));
                n++;
            end
            send_beat(random_beat(OP_ESTIMATE));
        end
        quiet = 1'b0;
        drain();
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) rank_shadow[i] = '0;
        prec_shadow = P_RESET;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_empty_full_precision();
        test_directed_edges();
        test_precision_clamps();
        test_random_phases();
        repeat (200) @(posedge aclk);
        $display("%0d beats sent, %0d estimates checked (raw %0d, linear %0d, large %0d)",
                 beats_sent, estimates_seen, corr_seen[0], corr_seen[1], corr_seen[2]);
        $display("%0d saturated estimates, %0d mismatches", saturated_seen, mismatches);
        if (mismatches == 0 && pending_estimates.size() == 0) begin
            $display("PASS hyperloglog_cardinality_sketch_top");
        end else begin
            $display("FAIL hyperloglog_cardinality_sketch_top");
        end
        $finish;
    end

endmodule
